@@ hw/rtl/mfje_pkg.sv @@
package mfje_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int RATIO_SHIFT = 16;
   localparam int NAXES       = 4;
   localparam int NMAP        = 2 * NAXES;
   localparam int MIN_DT_US   = 100;
   localparam int DIV_W       = 56;
   localparam int DEN_W       = 33;
   localparam int CNT_W       = $clog2(DIV_W + 1);
   localparam int QW          = 49;
   localparam int SAT_W       = 50;

   localparam logic [31:0]        RATIO_ONE   = 32'(1 << RATIO_SHIFT);
   localparam logic signed [31:0] VEL_LIMIT   = 32'(80 * (1 << FRAC_BITS));
   localparam logic signed [20:0] US_PER_S    = 21'sd1000000;
   localparam logic [31:0]        DECAY_BIAS  = 32'd19;
   localparam logic [31:0]        DECAY_MAGIC = 32'hCCCCCCCD;

   typedef enum logic [2:0] {
      CSR_GEAR_A,
      CSR_GEAR_B,
      CSR_GEAR_C,
      CSR_GEAR_D,
      CSR_PERIOD
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_AX_PREP,
      OP_DIV_START,
      OP_AX_WB,
      OP_MAP_PREP,
      OP_MAP_WB,
      OP_OUT
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AX_PREP,
      ST_AX_DIV,
      ST_AX_WAIT,
      ST_AX_WB,
      ST_MAP_PREP,
      ST_MAP_DIV,
      ST_MAP_WAIT,
      ST_MAP_WB,
      ST_OUT
   } state_type;

   typedef struct packed {
      op_type     op;
      logic [2:0] idx;
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_done;
   } sts_type;

   typedef struct packed {
      logic signed [31:0] motor_pos_0;
      logic signed [31:0] motor_pos_1;
      logic signed [31:0] motor_pos_2;
      logic signed [31:0] motor_pos_3;
      logic signed [31:0] motor_vel_0;
      logic signed [31:0] motor_vel_1;
      logic signed [31:0] motor_vel_2;
      logic signed [31:0] motor_vel_3;
      logic [3:0]         pos_valid_mask;
      logic [3:0]         vel_valid_mask;
      logic [31:0]        time_us;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] joint_pos_0;
      logic signed [31:0] joint_pos_1;
      logic signed [31:0] joint_pos_2;
      logic signed [31:0] joint_pos_3;
      logic signed [31:0] joint_vel_0;
      logic signed [31:0] joint_vel_1;
      logic signed [31:0] joint_vel_2;
      logic signed [31:0] joint_vel_3;
      logic               all_pos_valid;
   } rsp_payload_type;

   function automatic logic signed [31:0] sat_q(input logic signed [SAT_W-1:0] v);
      logic fits;
      fits = (&v[SAT_W-1:31]) || !(|v[SAT_W-1:31]);
      if (fits) begin
         return v[31:0];
      end else if (v[SAT_W-1]) begin
         return 32'sh80000000;
      end else begin
         return 32'sh7FFFFFFF;
      end
   endfunction

   function automatic logic signed [SAT_W-1:0] half_tz(input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] t;
      t = v + SAT_W'({1'b0, v[SAT_W-1]});
      return t >>> 1;
   endfunction

endpackage

@@ hw/rtl/mfje_div.sv @@
module mfje_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [mfje_pkg::DIV_W-1:0]    num,
   input  logic        [mfje_pkg::DEN_W-1:0]    den,
   output logic signed [mfje_pkg::DIV_W-1:0]    quo,
   output logic                                 done
);
   import mfje_pkg::*;

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DIV_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             neg_ff, neg_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   sub;
   logic             ge;

   always_comb begin
      trial   = {rem_ff, acc_ff[DIV_W-1]};
      sub     = trial - {1'b0, den_ff};
      ge      = trial >= {1'b0, den_ff};
      rem_in  = rem_ff;
      den_in  = den_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         den_in  = den;
         acc_in  = num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
         cnt_in  = '0;
         busy_in = 1'b1;
         neg_in  = num[DIV_W-1];
      end else if (busy_ff) begin
         if (cnt_ff == CNT_W'(DIV_W)) begin
            acc_in  = neg_ff ? DIV_W'(-acc_ff) : acc_ff;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            rem_in = ge ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
            acc_in = {acc_ff[DIV_W-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      acc_ff <= acc_in;
      neg_ff <= neg_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quo  = acc_ff;
   assign done = done_ff;

endmodule

@@ hw/rtl/mfje_dp.sv @@
module mfje_dp (
   input  logic                       clock,
   input  logic                       reset,
   input  mfje_pkg::cmd_type          cmd,
   output mfje_pkg::sts_type          sts,
   input  mfje_pkg::req_payload_type  req_payload,
   output mfje_pkg::rsp_payload_type  rsp_payload,
   input  logic                       csr_we,
   input  logic [2:0]                 csr_index,
   input  logic [31:0]                csr_wdata
);
   import mfje_pkg::*;

   req_payload_type    in_ff, in_in;
   rsp_payload_type    rsp_ff, rsp_in;
   logic [31:0]        gear_ff [NAXES];
   logic signed [31:0] lp_ff [NAXES];
   logic signed [31:0] lp_in [NAXES];
   logic signed [31:0] lv_ff [NAXES];
   logic signed [31:0] lv_in [NAXES];
   logic [31:0]        lt_ff [NAXES];
   logic [31:0]        lt_in [NAXES];
   logic [NAXES-1:0]   seen_ff, seen_in;
   logic signed [DIV_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic signed [QW-1:0] quo_ff [NMAP];
   logic signed [QW-1:0] quo_in [NMAP];

   logic signed [DIV_W-1:0] div_q;
   logic               div_done;

   logic signed [31:0] pos_a [NAXES];
   logic signed [31:0] vel_a [NAXES];
   logic [1:0]         k;
   logic               pvalid;
   logic               vvalid;
   logic signed [32:0] diff;
   logic signed [53:0] prod;
   logic [31:0]        dt;
   logic [31:0]        dt_fl;
   logic [31:0]        dmag;
   logic [31:0]        dy;
   logic [61:0]        dprod;
   logic [31:0]        dq;
   logic [31:0]        dres;
   logic signed [31:0] decayed;
   logic signed [31:0] raw;
   logic signed [34:0] s;
   logic signed [34:0] est;
   logic signed [31:0] v_new;
   logic signed [31:0] map_src;
   logic [31:0]        map_gear;
   logic signed [SAT_W-1:0] qa [NMAP];
   logic               need_div;

   mfje_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.op == OP_DIV_START),
      .num   (num_ff),
      .den   (den_ff),
      .quo   (div_q),
      .done  (div_done)
   );

   always_comb begin
      pos_a[0] = in_ff.motor_pos_0;
      pos_a[1] = in_ff.motor_pos_1;
      pos_a[2] = in_ff.motor_pos_2;
      pos_a[3] = in_ff.motor_pos_3;
      vel_a[0] = in_ff.motor_vel_0;
      vel_a[1] = in_ff.motor_vel_1;
      vel_a[2] = in_ff.motor_vel_2;
      vel_a[3] = in_ff.motor_vel_3;
      k        = cmd.idx[1:0];
      pvalid   = in_ff.pos_valid_mask[k];
      vvalid   = in_ff.vel_valid_mask[k];
      need_div = pvalid && !vvalid && seen_ff[k];
      diff     = {pos_a[k][31], pos_a[k]} - {lp_ff[k][31], lp_ff[k]};
      prod     = diff * US_PER_S;
      dt       = in_ff.time_us - lt_ff[k];
      dt_fl    = (dt < 32'(MIN_DT_US)) ? 32'(MIN_DT_US) : dt;
      // 19/20 of the magnitude is m - ceil(m/20); divide by 5 through a reciprocal
      dmag     = lv_ff[k][31] ? 32'(-lv_ff[k]) : lv_ff[k];
      dy       = (dmag + DECAY_BIAS) >> 2;
      dprod    = dy[29:0] * DECAY_MAGIC;
      dq       = {4'd0, dprod[61:34]};
      dres     = dmag - dq;
      decayed  = lv_ff[k][31] ? -$signed(dres) : $signed(dres);
      if (div_q > DIV_W'(VEL_LIMIT)) begin
         raw = VEL_LIMIT;
      end else if (div_q < -DIV_W'(VEL_LIMIT)) begin
         raw = -VEL_LIMIT;
      end else begin
         raw = div_q[31:0];
      end
      s   = 35'(lv_ff[k]) * 35'sd3 + 35'(raw);
      est = (s + (s[34] ? 35'sd3 : 35'sd0)) >>> 2;
      priority if (!pvalid) begin
         v_new = decayed;
      end else if (vvalid) begin
         v_new = vel_a[k];
      end else if (seen_ff[k]) begin
         v_new = sat_q(SAT_W'(est));
      end else begin
         v_new = '0;
      end
      map_src  = cmd.idx[2] ? lv_ff[cmd.idx[1:0]] : lp_ff[cmd.idx[1:0]];
      map_gear = gear_ff[cmd.idx[1:0]];
      for (int i = 0; i < NMAP; i++) begin
         qa[i] = SAT_W'(quo_ff[i]);
      end
   end

   always_comb begin
      in_in   = in_ff;
      rsp_in  = rsp_ff;
      lp_in   = lp_ff;
      lv_in   = lv_ff;
      lt_in   = lt_ff;
      seen_in = seen_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      unique case (cmd.op)
         OP_LOAD: begin
            in_in = req_payload;
         end
         OP_AX_PREP: begin
            num_in = DIV_W'(prod);
            den_in = {1'b0, dt_fl};
         end
         OP_AX_WB: begin
            lv_in[k] = v_new;
            if (pvalid) begin
               lp_in[k]   = pos_a[k];
               lt_in[k]   = in_ff.time_us;
               seen_in[k] = 1'b1;
            end
         end
         OP_MAP_PREP: begin
            num_in = DIV_W'(map_src) <<< RATIO_SHIFT;
            den_in = (map_gear == '0) ? DEN_W'(1) : {1'b0, map_gear};
         end
         OP_MAP_WB: begin
            quo_in[cmd.idx] = div_q[QW-1:0];
         end
         OP_OUT: begin
            rsp_in.joint_pos_0   = sat_q(half_tz(qa[0] - qa[1]));
            rsp_in.joint_pos_1   = sat_q(half_tz(qa[0] + qa[1]));
            rsp_in.joint_pos_2   = sat_q(qa[2]);
            rsp_in.joint_pos_3   = sat_q(qa[3]);
            rsp_in.joint_vel_0   = sat_q(half_tz(qa[4] - qa[5]));
            rsp_in.joint_vel_1   = sat_q(half_tz(qa[4] + qa[5]));
            rsp_in.joint_vel_2   = sat_q(qa[6]);
            rsp_in.joint_vel_3   = sat_q(qa[7]);
            rsp_in.all_pos_valid = &in_ff.pos_valid_mask;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      rsp_ff <= rsp_in;
      num_ff <= num_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      if (reset) begin
         for (int i = 0; i < NAXES; i++) begin
            gear_ff[i] <= RATIO_ONE;
            lp_ff[i]   <= '0;
            lv_ff[i]   <= '0;
            lt_ff[i]   <= '0;
         end
         seen_ff <= '0;
      end else begin
         lp_ff   <= lp_in;
         lv_ff   <= lv_in;
         lt_ff   <= lt_in;
         seen_ff <= seen_in;
         if (csr_we && csr_index <= CSR_GEAR_D) begin
            gear_ff[csr_index[1:0]] <= csr_wdata;
         end
      end
   end

   assign sts.need_div = need_div;
   assign sts.div_done = div_done;
   assign rsp_payload  = rsp_ff;

endmodule

@@ hw/rtl/mfje_ctrl.sv @@
module mfje_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  mfje_pkg::sts_type sts,
   output mfje_pkg::cmd_type cmd
);
   import mfje_pkg::*;

   state_type  state_ff, state_in;
   logic [2:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd.op       = OP_NONE;
      cmd.idx      = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               idx_in   = '0;
               state_in = ST_AX_PREP;
            end
         end
         ST_AX_PREP: begin
            cmd.op   = OP_AX_PREP;
            state_in = sts.need_div ? ST_AX_DIV : ST_AX_WB;
         end
         ST_AX_DIV: begin
            cmd.op   = OP_DIV_START;
            state_in = ST_AX_WAIT;
         end
         ST_AX_WAIT: begin
            if (sts.div_done) begin
               state_in = ST_AX_WB;
            end
         end
         ST_AX_WB: begin
            cmd.op = OP_AX_WB;
            if (idx_ff == 3'(NAXES - 1)) begin
               idx_in   = '0;
               state_in = ST_MAP_PREP;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_AX_PREP;
            end
         end
         ST_MAP_PREP: begin
            cmd.op   = OP_MAP_PREP;
            state_in = ST_MAP_DIV;
         end
         ST_MAP_DIV: begin
            cmd.op   = OP_DIV_START;
            state_in = ST_MAP_WAIT;
         end
         ST_MAP_WAIT: begin
            if (sts.div_done) begin
               state_in = ST_MAP_WB;
            end
         end
         ST_MAP_WB: begin
            cmd.op = OP_MAP_WB;
            if (idx_ff == 3'(NMAP - 1)) begin
               state_in = ST_OUT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_MAP_PREP;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hw/rtl/motor_feedback_joint_estimator.sv @@
// Four-axis motor feedback to joint estimator. Each sample carries motor positions,
// velocities, validity masks and a microsecond timestamp; per axis the block holds the
// position and decays velocity by 19/20 when the position is missing, takes a measured
// velocity when present, starts at zero on an axis's first sample, and otherwise forms
// a finite-difference estimate (elapsed time floored at 100 us, clamped to +-80 rad/s,
// low-passed with alpha 1/4). Joint values come from an inverse differential on motors
// 1 and 2 and gear division on 3 and 4, all signed Q15.16 saturated. One sample is
// worked at a time through a single shared one-bit-per-step divider, used eight times
// for the joint mapping plus once for each axis that estimates from the position
// difference; each division runs through prep, start, wait and write-back states, and
// an axis without a division goes from prep straight to write-back. The finished result
// sits in an output register, so the next sample is taken while it waits. The user
// makes gear ratio writes via the csr_ port only when the block is idle (not enforced).
module motor_feedback_joint_estimator (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  mfje_pkg::req_payload_type  req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output mfje_pkg::rsp_payload_type  rsp_payload,
   input  logic                       csr_we,
   input  logic [2:0]                 csr_index,
   input  logic [31:0]                csr_wdata
);
   import mfje_pkg::*;

   cmd_type cmd;
   sts_type sts;

   mfje_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mfje_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

endmodule

@@ hw/rtl/mfje_check.sv @@
module mfje_check (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input mfje_pkg::req_payload_type  req_payload,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input mfje_pkg::rsp_payload_type  rsp_payload
);
   import mfje_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new transaction taken while a sample is in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result changed");

   a_no_result_without_work: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && req_ready) |=> !rsp_valid)
      else $error("result appeared without a transaction");

endmodule

bind motor_feedback_joint_estimator mfje_check u_mfje_check (.*);

@@ tb/motor_feedback_joint_estimator_checker.sv @@
module motor_feedback_joint_estimator_checker
   import mfje_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_payload,
   input  logic            csr_we,
   input  logic [2:0]      csr_index,
   input  logic [31:0]     csr_wdata,
   output int              fail_count,
   output int              joints_pending,
   output int              joints_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint QMAX = 64'sd2147483647;
   localparam longint QMIN = -64'sd2147483648;
   localparam longint SPEED_CAP = longint'(80) <<< FRAC_BITS;

   logic signed [31:0] axis_pos[NAXES];
   logic signed [31:0] axis_vel[NAXES];
   logic [31:0]        axis_stamp[NAXES];
   logic               axis_seen[NAXES];
   logic [31:0]        gear[NAXES];
   logic [19:0]        period_us;
   rsp_payload_type    joint_queue[$];

   function automatic logic signed [31:0] clip32(input longint v);
      if (v > QMAX) return 32'sh7FFFFFFF;
      if (v < QMIN) return 32'sh80000000;
      return 32'(v);
   endfunction

   function automatic longint geared(input longint v, input logic [31:0] r);
      longint d;
      d = (r == 32'd0) ? 64'sd1 : longint'({32'd0, r});
      return (v * 65536) / d;
   endfunction

   function automatic void map_axes(input logic signed [31:0] m[NAXES],
                                    output logic signed [31:0] j[NAXES]);
      longint a;
      longint b;
      a = geared(longint'(m[0]), gear[0]);
      b = geared(longint'(m[1]), gear[1]);
      j[0] = clip32((a - b) / 2);
      j[1] = clip32((a + b) / 2);
      j[2] = clip32(geared(longint'(m[2]), gear[2]));
      j[3] = clip32(geared(longint'(m[3]), gear[3]));
   endfunction

   function automatic rsp_payload_type estimate_joints(input req_payload_type s);
      logic signed [31:0] mpos[NAXES];
      logic signed [31:0] mvel[NAXES];
      logic signed [31:0] vel_now[NAXES];
      logic signed [31:0] jp[NAXES];
      logic signed [31:0] jv[NAXES];
      logic [31:0]        dt;
      longint             raw;
      longint             v;
      rsp_payload_type    r;
      mpos = '{s.motor_pos_0, s.motor_pos_1, s.motor_pos_2, s.motor_pos_3};
      mvel = '{s.motor_vel_0, s.motor_vel_1, s.motor_vel_2, s.motor_vel_3};
      for (int i = 0; i < NAXES; i++) begin
         if (!s.pos_valid_mask[i]) begin
            axis_vel[i] = 32'((longint'(axis_vel[i]) * 19) / 20);
         end else begin
            if (s.vel_valid_mask[i]) begin
               v = longint'(mvel[i]);
            end else if (axis_seen[i]) begin
               dt = s.time_us - axis_stamp[i];
               if (dt < MIN_DT_US) dt = MIN_DT_US;
               raw = ((longint'(mpos[i]) - longint'(axis_pos[i])) * 1000000)
                     / longint'({32'd0, dt});
               if (raw > SPEED_CAP) raw = SPEED_CAP;
               if (raw < -SPEED_CAP) raw = -SPEED_CAP;
               v = (3 * longint'(axis_vel[i]) + raw) / 4;
            end else begin
               v = 0;
            end
            axis_pos[i] = mpos[i];
            axis_vel[i] = clip32(v);
            axis_stamp[i] = s.time_us;
            axis_seen[i] = 1'b1;
         end
         vel_now[i] = axis_vel[i];
      end
      map_axes(axis_pos, jp);
      map_axes(vel_now, jv);
      r.joint_pos_0 = jp[0];
      r.joint_pos_1 = jp[1];
      r.joint_pos_2 = jp[2];
      r.joint_pos_3 = jp[3];
      r.joint_vel_0 = jv[0];
      r.joint_vel_1 = jv[1];
      r.joint_vel_2 = jv[2];
      r.joint_vel_3 = jv[3];
      r.all_pos_valid = (s.pos_valid_mask == 4'hF);
      return r;
   endfunction

   task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
      $display("%0t mismatch %s: got %h expected %h", $realtime, field, got, want);
      fail_count++;
   endtask

   task automatic compare_joints(input rsp_payload_type g, input rsp_payload_type e);
      if (g.joint_pos_0 !== e.joint_pos_0) report("joint_pos_0", g.joint_pos_0, e.joint_pos_0);
      if (g.joint_pos_1 !== e.joint_pos_1) report("joint_pos_1", g.joint_pos_1, e.joint_pos_1);
      if (g.joint_pos_2 !== e.joint_pos_2) report("joint_pos_2", g.joint_pos_2, e.joint_pos_2);
      if (g.joint_pos_3 !== e.joint_pos_3) report("joint_pos_3", g.joint_pos_3, e.joint_pos_3);
      if (g.joint_vel_0 !== e.joint_vel_0) report("joint_vel_0", g.joint_vel_0, e.joint_vel_0);
      if (g.joint_vel_1 !== e.joint_vel_1) report("joint_vel_1", g.joint_vel_1, e.joint_vel_1);
      if (g.joint_vel_2 !== e.joint_vel_2) report("joint_vel_2", g.joint_vel_2, e.joint_vel_2);
      if (g.joint_vel_3 !== e.joint_vel_3) report("joint_vel_3", g.joint_vel_3, e.joint_vel_3);
      if (g.all_pos_valid !== e.all_pos_valid)
         report("all_pos_valid", 32'(g.all_pos_valid), 32'(e.all_pos_valid));
   endtask

   initial begin
      fail_count = 0;
      joints_checked = 0;
   end

   assign joints_pending = joint_queue.size();

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NAXES; i++) begin
            axis_pos[i] <= '0;
            axis_vel[i] <= '0;
            axis_stamp[i] <= '0;
            axis_seen[i] <= 1'b0;
            gear[i] <= RATIO_ONE;
         end
         period_us <= 20'd1000;
         joint_queue.delete();
      end else begin
         if (csr_we) begin
            if (csr_index < CSR_PERIOD) gear[csr_index] = csr_wdata;
            else if (csr_index == CSR_PERIOD) period_us = csr_wdata[19:0];
         end
         if (rsp_valid && rsp_ready) begin
            if (joint_queue.size() == 0) begin
               $display("%0t unexpected transaction on rsp", $realtime);
               fail_count++;
            end else begin
               compare_joints(rsp_payload, joint_queue.pop_front());
               joints_checked++;
            end
         end
         if (req_valid && req_ready) joint_queue.push_back(estimate_joints(req_payload));
      end
   end

   final begin
      if (joint_queue.size() != 0)
         $display("%0d transactions still expected", joint_queue.size());
   end

endmodule

@@ tb/motor_feedback_joint_estimator_tb.sv @@
module motor_feedback_joint_estimator_tb;
   import mfje_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] CSR_SPARE = 3'd7;
   localparam int RANDOM_PER_PHASE = 135;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;
   logic            csr_we;
   logic [2:0]      csr_index;
   logic [31:0]     csr_wdata;
   int              fail_count;
   int              joints_pending;
   int              joints_checked;

   int                 samples_sent;
   bit                 send_burst;
   bit                 recv_burst;
   bit                 hold_off_due;
   logic [31:0]        now_us;
   logic signed [31:0] track[NAXES];

   motor_feedback_joint_estimator u_dut (.*);

   motor_feedback_joint_estimator_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      clock = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      rsp_ready <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= CSR_GEAR_A;
      csr_wdata <= '0;
   end

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic int draw_gap(input bit burst);
      return burst ? 0 : $urandom_range(0, 16);
   endfunction

   task automatic send_sample(input req_payload_type s);
      int gap;
      gap = draw_gap(send_burst);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= s;
      do @(posedge clock); while (!req_ready);
      samples_sent++;
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (joints_pending != 0) @(posedge clock);
   endtask

   function automatic req_payload_type make_sample(input logic [31:0] p0, p1, p2, p3,
                                                   input logic [31:0] v0, v1, v2, v3,
                                                   input logic [3:0] pm, vm,
                                                   input logic [31:0] t);
      req_payload_type s;
      s = '{p0, p1, p2, p3, v0, v1, v2, v3, pm, vm, t};
      return s;
   endfunction

   function automatic req_payload_type next_sample();
      req_payload_type s;
      logic signed [31:0] step;
      if ($urandom_range(0, 9) < 2) begin
         s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, 8'($urandom), $urandom};
         return s;
      end
      now_us = now_us + $urandom_range(0, 3000);
      for (int i = 0; i < NAXES; i++) begin
         step = 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
         track[i] = track[i] + step;
      end
      s = make_sample(track[0], track[1], track[2], track[3],
                      $urandom, $urandom, $urandom, $urandom, '0, '0, now_us);
      for (int i = 0; i < NAXES; i++) begin
         s.pos_valid_mask[i] = ($urandom_range(0, 99) < 85);
         s.vel_valid_mask[i] = ($urandom_range(0, 99) < 25);
      end
      return s;
   endfunction

   task automatic random_phase();
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
         if (n % 40 == 0) send_burst = $urandom_range(0, 2) == 0;
         send_sample(next_sample());
      end
      drain();
   endtask

   always begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_due) begin
            rsp_ready <= 1'b0;
            repeat (4000) @(posedge clock);
            hold_off_due = 1'b0;
         end
         if (joints_checked % 50 == 0) recv_burst = $urandom_range(0, 2) == 0;
         gap = draw_gap(recv_burst);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      int guard;
      samples_sent = 0;
      send_burst = 1'b0;
      recv_burst = 1'b0;
      hold_off_due = 1'b0;
      now_us = 32'd1000;
      for (int i = 0; i < NAXES; i++) track[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_sample(make_sample(32'h10000, 32'h20000, -32'sh10000, 32'h8000,
                              '0, '0, '0, '0, 4'hF, 4'h0, 32'd1000));
      send_sample(make_sample(32'h10CCC, 32'h1F000, -32'sh11000, 32'h8000,
                              '0, '0, '0, '0, 4'hF, 4'h0, 32'd2000));
      send_sample(make_sample(32'h7FFFFFFF, 32'h80000000, 32'h40000000, 32'hC0000000,
                              '0, '0, '0, '0, 4'hF, 4'h0, 32'd2010));
      send_sample(make_sample(32'h80000000, 32'h7FFFFFFF, 32'hC0000000, 32'h40000000,
                              '0, '0, '0, '0, 4'hF, 4'h0, 32'd2010));
      send_sample(make_sample('0, '0, '0, '0, 32'h7FFFFFFF, 32'h80000000,
                              32'hFFFFFFFF, 32'h00000001, 4'hF, 4'hF, 32'd3000));
      send_sample(make_sample('0, '0, '0, '0, '0, '0, '0, '0, 4'h0, 4'hF, 32'd4000));
      send_sample(make_sample('0, '0, '0, '0, '0, '0, '0, '0, 4'h0, 4'h0, 32'd5000));
      send_sample(make_sample(32'h30000, 32'h30000, 32'h30000, 32'h30000,
                              '0, '0, '0, '0, 4'h5, 4'h0, 32'd6000));
      send_sample(make_sample(32'h31000, 32'h31000, 32'h31000, 32'h31000,
                              '0, '0, '0, '0, 4'hA, 4'h0, 32'd7000));
      send_sample(make_sample(32'h50000, 32'h50000, 32'h50000, 32'h50000,
                              '0, '0, '0, '0, 4'hF, 4'h0, 32'd5));
      send_sample(make_sample(32'h50100, 32'h4FF00, 32'h50100, 32'h4FF00,
                              '0, '0, '0, '0, 4'hF, 4'h0, 32'hFFFFFF00));
      send_sample(make_sample(32'h50200, 32'h4FE00, 32'h50200, 32'h4FE00,
                              '0, '0, '0, '0, 4'hF, 4'h3, 32'h00000010));
      send_sample(make_sample(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                              '0, '0, '0, '0, 4'hF, 4'h0, 32'hFFFFFFFF));
      hold_off_due = 1'b1;
      random_phase();

      write_reg(CSR_GEAR_A, 32'd0);
      write_reg(CSR_GEAR_B, 32'hFFFFFFFF);
      write_reg(CSR_GEAR_C, 32'd1);
      write_reg(CSR_GEAR_D, $urandom);
      write_reg(CSR_PERIOD, 32'd1);
      csr_we <= 1'b0;
      random_phase();

      write_reg(CSR_GEAR_A, $urandom_range(32'h8000, 32'h40000));
      write_reg(CSR_GEAR_B, $urandom_range(32'h8000, 32'h40000));
      write_reg(CSR_GEAR_C, 32'd0);
      write_reg(CSR_GEAR_D, 32'hFFFFFFFF);
      write_reg(CSR_PERIOD, 32'd1000000);
      write_reg(CSR_SPARE, $urandom);
      csr_we <= 1'b0;
      random_phase();

      write_reg(CSR_GEAR_A, 32'h00020000);
      write_reg(CSR_GEAR_B, 32'h00008000);
      write_reg(CSR_GEAR_C, $urandom_range(32'h100, 32'h100000));
      write_reg(CSR_GEAR_D, $urandom_range(32'h100, 32'h100000));
      write_reg(CSR_PERIOD, 32'hFFFFFFFF);
      csr_we <= 1'b0;
      random_phase();

      guard = 0;
      while (joints_pending != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (1000) @(posedge clock);
      $display("Covered %0d samples over four gear settings, %0d joint results checked",
               samples_sent, joints_checked);
      $display("including first samples, clamped estimates, decays and timestamp wraps");
      if (fail_count == 0 && joints_pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
